@@ rtl/core/mbd_pkg.sv @@
package mbd_pkg;

    localparam int unsigned PIN_W     = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DEB_W     = 20;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_ACTIVE_LOW = 2'd1;
    localparam logic [1:0] REG_WIRED_MASK = 2'd2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST   = 20'd20000;
    localparam logic             ACTIVE_LOW_RST = 1'b1;
    localparam logic [PIN_W-1:0] WIRED_MASK_RST = 16'hFFFF;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FORCE  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [PIN_W-1:0]  pin_levels;
        logic [TIME_W-1:0] time_now;
        logic [IDX_W-1:0]  button_index;
        logic              force_level;
    } t_in_word;

    typedef struct packed {
        logic [PIN_W-1:0] stable_pressed;
        logic [PIN_W-1:0] went_down;
        logic [PIN_W-1:0] went_up;
    } t_out_word;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_time;
        logic             active_low;
        logic [PIN_W-1:0] wired_mask;
    } t_cfg;

    // shared per-word command broadcast to every lane
    typedef struct packed {
        logic              en;
        logic              sample;
        logic              force_en;
        logic              force_level;
        logic [TIME_W-1:0] time_now;
        logic [DEB_W-1:0]  debounce_time;
    } t_lane_cmd;

    typedef struct packed {
        logic stable;
        logic prev;
    } t_lane_stat;

endpackage

@@ rtl/core/mbd_cfg.sv @@
module mbd_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mbd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mbd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output mbd_pkg::t_cfg                     o_cfg
);

    mbd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= mbd_pkg::DEBOUNCE_RST;
            r_cfg.active_low    <= mbd_pkg::ACTIVE_LOW_RST;
            r_cfg.wired_mask    <= mbd_pkg::WIRED_MASK_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                mbd_pkg::REG_DEBOUNCE:   r_cfg.debounce_time <= pwdata[mbd_pkg::DEB_W-1:0];
                mbd_pkg::REG_ACTIVE_LOW: r_cfg.active_low    <= pwdata[0];
                mbd_pkg::REG_WIRED_MASK: r_cfg.wired_mask    <= pwdata[mbd_pkg::PIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mbd_pkg::REG_DEBOUNCE:
                prdata = {{(mbd_pkg::APB_DATA_W-mbd_pkg::DEB_W){1'b0}}, r_cfg.debounce_time};
            mbd_pkg::REG_ACTIVE_LOW:
                prdata = {{(mbd_pkg::APB_DATA_W-1){1'b0}}, r_cfg.active_low};
            mbd_pkg::REG_WIRED_MASK:
                prdata = {{(mbd_pkg::APB_DATA_W-mbd_pkg::PIN_W){1'b0}}, r_cfg.wired_mask};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/mbd_lane.sv @@
module mbd_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mbd_pkg::t_lane_cmd    i_cmd,
    input  logic                  i_raw,
    input  logic                  i_sel,
    output mbd_pkg::t_lane_stat   o_next
);

    logic                        r_seen, n_seen;
    logic [mbd_pkg::TIME_W-1:0]  r_stamp, n_stamp;
    logic                        r_stable, n_stable;
    logic                        r_prev, n_prev;
    logic [mbd_pkg::TIME_W-1:0]  elapsed;
    logic                        settled;

    // wraps mod 2^32 by construction
    assign elapsed = i_cmd.time_now - r_stamp;
    assign settled = elapsed >= {{(mbd_pkg::TIME_W-mbd_pkg::DEB_W){1'b0}}, i_cmd.debounce_time};

    always_comb begin
        n_seen   = r_seen;
        n_stamp  = r_stamp;
        n_stable = r_stable;
        n_prev   = r_prev;
        if (i_cmd.sample) begin
            if (i_raw != r_seen) begin
                n_seen  = i_raw;
                n_stamp = i_cmd.time_now;
            end else if (settled) begin
                n_prev   = r_stable;
                n_stable = i_raw;
            end
        end else if (i_cmd.force_en && i_sel) begin
            n_prev   = r_stable;
            n_stable = i_cmd.force_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 1'b0;
            r_stamp  <= '0;
            r_stable <= 1'b0;
            r_prev   <= 1'b0;
        end else if (i_cmd.en) begin
            r_seen   <= n_seen;
            r_stamp  <= n_stamp;
            r_stable <= n_stable;
            r_prev   <= n_prev;
        end
    end

    assign o_next.stable = n_stable;
    assign o_next.prev   = n_prev;

endmodule

@@ rtl/core/mbd_merge.sv @@
module mbd_merge #(
    parameter int unsigned NUM_BUTTONS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [NUM_BUTTONS-1:0]  i_stable,
    input  logic [NUM_BUTTONS-1:0]  i_prev,
    input  logic                    i_out_ready,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output mbd_pkg::t_out_word      o_out_word
);

    logic [mbd_pkg::PIN_W-1:0] stab16;
    logic [mbd_pkg::PIN_W-1:0] prev16;
    logic                      r_valid;
    mbd_pkg::t_out_word        r_word;

    // only the first sixteen buttons are visible in the result
    for (genvar k = 0; k < mbd_pkg::PIN_W; k++) begin : g_vis
        if (k < NUM_BUTTONS) begin : g_on
            assign stab16[k] = i_stable[k];
            assign prev16[k] = i_prev[k];
        end else begin : g_off
            assign stab16[k] = 1'b0;
            assign prev16[k] = 1'b0;
        end
    end

    assign o_in_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word.stable_pressed <= stab16;
            r_word.went_down      <= stab16 & ~prev16;
            r_word.went_up        <= ~stab16 & prev16;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

@@ rtl/core/multi_button_debouncer_top.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready    i_in_word  (mbd_pkg::t_in_word)
// output    out        o_out_valid / i_out_ready  o_out_word (mbd_pkg::t_out_word)
// config    in         psel/penable/pwrite        paddr, pwdata -> prdata, pready
//
// One word per cycle while the output is not stalled; its result appears in the output register on the next cycle.
// Lane next-state logic feeds the single output register directly; that register is
// the whole latency.
// Synchronous active-low reset clears all lane state and loads register defaults.
// A stalled output holds; a new word is taken in the cycle the held word leaves.
module multi_button_debouncer_top #(
    parameter int unsigned NUM_BUTTONS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mbd_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mbd_pkg::t_out_word                o_out_word,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mbd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mbd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    mbd_pkg::t_cfg       cfg;
    mbd_pkg::t_lane_cmd  lane_cmd;
    logic                accept;
    logic [NUM_BUTTONS-1:0] lane_stable;
    logic [NUM_BUTTONS-1:0] lane_prev;

    assign accept = i_in_valid && o_in_ready;

    mbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign lane_cmd.en            = accept;
    assign lane_cmd.sample        = i_in_word.cmd == mbd_pkg::CMD_SAMPLE;
    assign lane_cmd.force_en      = i_in_word.cmd == mbd_pkg::CMD_FORCE;
    assign lane_cmd.force_level   = i_in_word.force_level;
    assign lane_cmd.time_now      = i_in_word.time_now;
    assign lane_cmd.debounce_time = cfg.debounce_time;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        logic                raw;
        logic                sel;
        mbd_pkg::t_lane_stat stat;

        if (i < mbd_pkg::PIN_W) begin : g_pin
            // pressed = level xor active_low, unwired reads released
            assign raw = cfg.wired_mask[i] & (i_in_word.pin_levels[i] ^ cfg.active_low);
            assign sel = i_in_word.button_index == mbd_pkg::IDX_W'(i);
        end else begin : g_nopin
            assign raw = 1'b0;
            assign sel = 1'b0;
        end

        mbd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (lane_cmd),
            .i_raw   (raw),
            .i_sel   (sel),
            .o_next  (stat)
        );

        assign lane_stable[i] = stat.stable;
        assign lane_prev[i]   = stat.prev;
    end

    mbd_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_stable    (lane_stable),
        .i_prev      (lane_prev),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
